/* rtl/core/pcte_pkg.sv */
// Package for the prefix code table encoder.
// Holds table sizes, item kind codes and the packer command and result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcte_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int MAX_CODE_BITS = 8;
  localparam int TBL_AW        = $clog2(TABLE_DEPTH);

  localparam int KIND_W   = 2;
  localparam int SYMBOL_W = 8;
  localparam int CODE_W   = 8;
  localparam int LEN_W    = 4;
  localparam int ENTRY_W  = LEN_W + CODE_W;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 3;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_ENTRY = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } pack_cmd_t;

  typedef struct packed {
    logic              has_result;
    logic [BYTE_W-1:0] out_byte;
    logic              status;
  } pack_res_t;

endpackage

`default_nettype wire

/* rtl/core/pcte_if.sv */
// Valid/ready channels for the prefix code table encoder.
// Input channel carries one item word, output channel one result word.
// Depends on pcte_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pcte_in_if import pcte_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SYMBOL_W-1:0] symbol;
  logic [CODE_W-1:0]   code_value;
  logic [LEN_W-1:0]    code_length;

  modport source (output valid, kind, symbol, code_value, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_value, code_length, output ready);
endinterface

interface pcte_out_if import pcte_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              status;

  modport source (output valid, out_byte, status, input ready);
  modport sink   (input valid, out_byte, status, output ready);
endinterface

`default_nettype wire

/* rtl/core/pcte_packer.sv */
// MSB-first byte packer of the prefix code table encoder.
// Holds the pack buffer and bit count; computes at most one result per word.
// Depends on pcte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcte_packer import pcte_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  pack_cmd_t cmd,
  output pack_res_t res
);

  logic [BYTE_W-1:0]   buffer;
  logic [CNT_W-1:0]    count;
  logic [BYTE_W-1:0]   buffer_next;
  logic [CNT_W-1:0]    count_next;

  logic [CODE_W-1:0]   code_mask;
  logic [4:0]          total;
  logic [3:0]          rem;
  logic [2*BYTE_W-1:0] acc;
  logic [2*BYTE_W-1:0] flush_acc;
  logic [2*BYTE_W-1:0] emit_acc;

  always_comb begin
    code_mask = ~(8'hFF << cmd.length);
    total     = 5'(count) + 5'(cmd.length);
    rem       = total[3:0] - 4'd8;
    acc       = ({8'b0, buffer} << cmd.length) | {8'b0, cmd.code & code_mask};
    emit_acc  = acc >> rem;
    flush_acc = {buffer, 8'b0} >> count;

    buffer_next    = buffer;
    count_next     = count;
    res.has_result = 1'b0;
    res.out_byte   = '0;
    res.status     = STATUS_OK;

    unique case (cmd.kind)
      KIND_ENCODE: begin
        if (!cmd.hit) begin
          res.has_result = 1'b1;
          res.status     = STATUS_NO_ENTRY;
        end else if (cmd.length <= MAX_LEN) begin
          if (total >= 5'd8) begin
            res.has_result = 1'b1;
            res.out_byte   = emit_acc[BYTE_W-1:0];
            buffer_next    = acc[BYTE_W-1:0] & ~(8'hFF << rem);
            count_next     = rem[CNT_W-1:0];
          end else begin
            buffer_next = acc[BYTE_W-1:0];
            count_next  = total[CNT_W-1:0];
          end
        end
      end
      KIND_FLUSH: begin
        res.has_result = 1'b1;
        res.out_byte   = flush_acc[BYTE_W-1:0];
        buffer_next    = '0;
        count_next     = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer <= '0;
      count  <= '0;
    end else if (advance) begin
      buffer <= buffer_next;
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/prefix_code_table_encoder.sv */
// Table-driven prefix code encoder with MSB-first byte packing, a user of the
// block sees one word per cycle: a word is taken every cycle while results
// are taken. A word is registered in the s1 stage and any result it gives in
// the output register, and a stall on the output can hold either. The code
// table is a 256-entry memory read at acceptance; entry valid bits clear at
// reset, so no clearing pass is needed. Depends on pcte_pkg, pcte_if and
// pcte_packer.
`timescale 1ns / 1ps
`default_nettype none

module prefix_code_table_encoder import pcte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pcte_in_if.sink     in_ch,
  pcte_out_if.source  out_ch
);

  localparam logic [SYMBOL_W:0] SYM_LIMIT = (SYMBOL_W + 1)'(TABLE_DEPTH);

  logic [ENTRY_W-1:0]     code_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic                   in_fire;
  logic                   s2_fire;
  logic [TBL_AW-1:0]      idx;
  logic                   in_range;

  logic                   s1_valid;
  logic [KIND_W-1:0]      s1_kind;
  logic                   s1_hit;
  logic [ENTRY_W-1:0]     s1_entry;

  pack_cmd_t              cmd;
  pack_res_t              res;

  assign idx          = in_ch.symbol[TBL_AW-1:0];
  assign in_range     = {1'b0, in_ch.symbol} < SYM_LIMIT;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s2_fire      = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s2_fire;

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.kind == KIND_LOAD && in_range) begin
      code_mem[idx] <= {in_ch.code_length, in_ch.code_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (in_fire && in_ch.kind == KIND_LOAD && in_range) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_entry <= code_mem[idx];
      s1_kind  <= in_ch.kind;
      s1_hit   <= in_range && entry_valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s2_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    cmd.kind   = s1_kind;
    cmd.hit    = s1_hit;
    cmd.code   = s1_entry[CODE_W-1:0];
    cmd.length = s1_entry[ENTRY_W-1:CODE_W];
  end

  pcte_packer u_packer (
    .clk     (clk),
    .rst     (rst),
    .advance (s2_fire),
    .cmd     (cmd),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (s2_fire) begin
      out_ch.valid <= res.has_result;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && res.has_result) begin
      out_ch.out_byte <= res.out_byte;
      out_ch.status   <= res.status;
    end
  end

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.kind == KIND_LOAD |=> entry_valid[$past(idx)])
    else $error("load did not mark its entry valid");

  a_miss_zero_byte: assert property (@(posedge clk) disable iff (rst)
    s2_fire && res.has_result && res.status == STATUS_NO_ENTRY |-> res.out_byte == '0)
    else $error("missing entry result carries nonzero byte");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_fire |=> s1_valid && $stable(s1_hit) && $stable(s1_kind))
    else $error("held word lost while output stalled");

  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    s2_fire && s1_kind == KIND_FLUSH |=> out_ch.valid && out_ch.status == STATUS_OK)
    else $error("flush gave no result");

endmodule

`default_nettype wire

/* test/tb_prefix_code_table_encoder.sv */
// Self-checking bench for prefix_code_table_encoder: loads code tables, encodes
// symbol streams and flushes, and checks every packed byte against a model.
// Depends on pcte_pkg, pcte_if and the encoder RTL.
`timescale 1ns / 1ps

module tb_prefix_code_table_encoder;
  import pcte_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_WORDS  = 1000;
  localparam int PHASES        = 4;
  localparam int MAX_GAP       = 4;
  localparam int SETTLE_CYCLES = 16;
  localparam longint TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              status;
  } byte_word_t;

  class packed_byte_board;
    logic              entry_loaded [TABLE_DEPTH];
    logic [CODE_W-1:0] entry_bits [TABLE_DEPTH];
    logic [LEN_W-1:0]  entry_len [TABLE_DEPTH];
    logic [BYTE_W-1:0] shift_reg;
    int                bit_count;
    byte_word_t        pending_bytes[$];
    int                failures;

    function new();
      foreach (entry_loaded[i]) begin
        entry_loaded[i] = 1'b0;
        entry_bits[i]   = '0;
        entry_len[i]    = '0;
      end
      shift_reg = '0;
      bit_count = 0;
      failures  = 0;
    endfunction

    function void expect_byte(logic [BYTE_W-1:0] value, logic status);
      byte_word_t w;
      w.out_byte = value;
      w.status   = status;
      pending_bytes = {pending_bytes, w};
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [SYMBOL_W-1:0] symbol,
                            logic [CODE_W-1:0] code_value, logic [LEN_W-1:0] code_length);
      logic [BYTE_W-1:0] aligned;
      case (kind)
        KIND_LOAD: begin
          entry_loaded[symbol] = 1'b1;
          entry_bits[symbol]   = code_value;
          entry_len[symbol]    = code_length;
        end
        KIND_ENCODE: begin
          if (!entry_loaded[symbol]) begin
            expect_byte('0, STATUS_NO_ENTRY);
          end else if (entry_len[symbol] <= MAX_LEN) begin
            for (int i = entry_len[symbol]; i > 0; i--) begin
              shift_reg = {shift_reg[BYTE_W-2:0], entry_bits[symbol][i-1]};
              bit_count++;
              if (bit_count == BYTE_W) begin
                expect_byte(shift_reg, STATUS_OK);
                shift_reg = '0;
                bit_count = 0;
              end
            end
          end
        end
        KIND_FLUSH: begin
          aligned = (bit_count == 0) ? '0 : BYTE_W'(shift_reg << (BYTE_W - bit_count));
          expect_byte(aligned, STATUS_OK);
          shift_reg = '0;
          bit_count = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [BYTE_W-1:0] out_byte, logic status);
      byte_word_t w;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual out_byte=%h status=%b",
                 $time, out_byte, status);
        failures++;
        return;
      end
      w = pending_bytes.pop_front();
      if (out_byte !== w.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h, actual %h", $time, w.out_byte, out_byte);
        failures++;
      end
      if (status !== w.status) begin
        $display("%0t: status mismatch: expected %b, actual %b", $time, w.status, status);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  pcte_in_if  in_ch ();
  pcte_out_if out_ch ();

  prefix_code_table_encoder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  packed_byte_board board = new();

  logic [SYMBOL_W-1:0] loaded_syms[$];
  logic                sym_seen [TABLE_DEPTH];
  int                  in_gap_max;
  int                  out_gap_max;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        board.check_byte(out_ch.out_byte, out_ch.status);
      if (in_ch.valid && in_ch.ready)
        board.note_item(in_ch.kind, in_ch.symbol, in_ch.code_value, in_ch.code_length);
    end
  end

  // Result side: hold ready low for a random gap, which may be empty, before each word.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_word(logic [KIND_W-1:0] kind, logic [SYMBOL_W-1:0] symbol,
                           logic [CODE_W-1:0] code_value, logic [LEN_W-1:0] code_length);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.kind        = kind;
    in_ch.symbol      = symbol;
    in_ch.code_value  = code_value;
    in_ch.code_length = code_length;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (kind == KIND_LOAD && !sym_seen[symbol]) begin
      sym_seen[symbol] = 1'b1;
      loaded_syms = {loaded_syms, symbol};
    end
  endtask

  task automatic send_random_word(output logic counted);
    int                  pick;
    int                  sel;
    logic [SYMBOL_W-1:0] symbol;
    logic [LEN_W-1:0]    code_length;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 15) begin
      sel = $urandom_range(0, 19);
      if (sel == 0)
        code_length = '0;
      else if (sel == 1)
        code_length = LEN_W'($urandom_range(MAX_CODE_BITS + 1, 15));
      else
        code_length = LEN_W'($urandom_range(1, MAX_CODE_BITS));
      send_word(KIND_LOAD, SYMBOL_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)),
                code_length);
    end else if (pick < 80) begin
      if (loaded_syms.size() > 0 && $urandom_range(0, 9) != 0)
        symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      else
        symbol = SYMBOL_W'($urandom_range(0, 255));
      send_word(KIND_ENCODE, symbol, CODE_W'($urandom_range(0, 255)),
                LEN_W'($urandom_range(0, 15)));
    end else if (pick < 95) begin
      send_word(KIND_FLUSH, SYMBOL_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)),
                LEN_W'($urandom_range(0, 15)));
    end else begin
      send_word(KIND_UNUSED, SYMBOL_W'($urandom_range(0, 255)), CODE_W'($urandom_range(0, 255)),
                LEN_W'($urandom_range(0, 15)));
      counted = 1'b0;
    end
  endtask

  initial begin
    int   sent;
    logic counted;
    foreach (sym_seen[i]) sym_seen[i] = 1'b0;
    in_gap_max        = MAX_GAP;
    out_gap_max       = MAX_GAP;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.kind        = KIND_LOAD;
    in_ch.symbol      = '0;
    in_ch.code_value  = '0;
    in_ch.code_length = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_word(KIND_FLUSH,  8'h00, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h00, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'hFF, 8'hFF, 4'd15);
    send_word(KIND_UNUSED, 8'hFF, 8'hFF, 4'd15);
    send_word(KIND_LOAD,   8'hFF, 8'hA5, 4'd8);
    send_word(KIND_LOAD,   8'h00, 8'h01, 4'd1);
    send_word(KIND_LOAD,   8'h80, 8'hFF, 4'd0);
    send_word(KIND_LOAD,   8'h7F, 8'hFF, 4'd15);
    send_word(KIND_LOAD,   8'h55, 8'hFA, 4'd3);
    send_word(KIND_LOAD,   8'h01, 8'h00, 4'd8);
    send_word(KIND_ENCODE, 8'hFF, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h80, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h7F, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h00, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h55, 8'h00, 4'd0);
    send_word(KIND_FLUSH,  8'h00, 8'h00, 4'd0);
    send_word(KIND_FLUSH,  8'h00, 8'h00, 4'd0);
    send_word(KIND_LOAD,   8'h00, 8'h5A, 4'd7);
    send_word(KIND_ENCODE, 8'h00, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h00, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h00, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h12, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'hFF, 8'h00, 4'd0);
    send_word(KIND_ENCODE, 8'h01, 8'h00, 4'd0);
    send_word(KIND_FLUSH,  8'h00, 8'h00, 4'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      in_gap_max  = (phase == 1 || phase == 3) ? 0 : MAX_GAP;
      out_gap_max = (phase == 1) ? 0 : MAX_GAP;
      sent = 0;
      while (sent < RANDOM_WORDS / PHASES) begin
        send_random_word(counted);
        if (counted) sent++;
      end
    end

    in_ch.valid = 1'b0;
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.failures == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
